@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of the segmenter.
// Each macro clocks on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define BJS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segmenter check failed");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define BJS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segmenter check failed");

`endif

@@ sv/bjs_pkg.sv @@
// Package of the bytecode jump-destination segmenter: opcodes, record kinds,
// the record and state types and the record builder. No dependencies.
package bjs_pkg;

   localparam int unsigned MAX_CODE_BYTES_DEF = 65536;

   localparam logic [7:0] OPC_JUMPDEST = 8'h5b;
   localparam logic [7:0] OPC_PUSH1    = 8'h60;
   localparam logic [7:0] OPC_PUSH32   = 8'h7f;

   localparam logic KIND_MAP = 1'b0;
   localparam logic KIND_SEG = 1'b1;

   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic        kind;
      logic [15:0] idx;
      logic [15:0] start_pc;
      logic [16:0] end_pc;
      logic        entry;
      logic        jump;
      logic        ovf;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic [5:0]  push_left;
      logic        open;
      logic [15:0] start;
      logic        entry;
      logic        jump;
      logic [15:0] next_idx;
      logic        prev_jd;
      logic        ovf;
   } seg_state_type;

   // The index carried by a record is that of the most recently opened segment.
   function automatic rec_type make_rec(input logic kind, input seg_state_type st,
                                        input logic [15:0] pc, input logic [16:0] end_pc);
      rec_type r;
      r.kind     = kind;
      r.idx      = st.next_idx - 16'd1;
      r.start_pc = pc;
      r.end_pc   = end_pc;
      r.entry    = st.entry;
      r.jump     = st.jump;
      r.ovf      = st.ovf;
      r.last     = 1'b0;
      return r;
   endfunction

endpackage

@@ sv/bjs_step.sv @@
// Combinational analysis of one bytecode byte: next state and up to three records.
// Depends on bjs_pkg.
module bjs_step #(
   parameter int unsigned MAX_CODE_BYTES = bjs_pkg::MAX_CODE_BYTES_DEF,
   parameter int          PC_W           = $clog2(MAX_CODE_BYTES + 1)
) (
   input  logic [7:0]              code_byte,
   input  logic                    last_byte,
   input  logic [PC_W-1:0]         pc,
   input  bjs_pkg::seg_state_type  st_cur,
   output logic [PC_W-1:0]         pc_next,
   output bjs_pkg::seg_state_type  st_next,
   output bjs_pkg::rec_type        recs [3],
   output logic [1:0]              rec_cnt
);

   localparam int EXT_W = (PC_W > 17) ? PC_W : 17;
   localparam logic [PC_W-1:0]  MAX_PC  = PC_W'(MAX_CODE_BYTES);
   localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_CODE_BYTES);

   logic [EXT_W-1:0]       pc_ext;
   logic [EXT_W-1:0]       pc1_ext;
   logic                   jd;
   logic [1:0]             n;
   bjs_pkg::seg_state_type st;

   assign pc_ext  = EXT_W'(pc);
   // pc stays below the bound here, so pc + 1 still fits PC_W bits.
   assign pc1_ext = EXT_W'(pc + PC_W'(1));

   always_comb begin
      n       = 2'd0;
      jd      = 1'b0;
      st      = st_cur;
      pc_next = pc;
      for (int i = 0; i < 3; i++) begin
         recs[i] = '0;
      end
      if (pc == MAX_PC) begin
         // Past the bound: bytes are not analysed, only a final close is given.
         st.ovf = 1'b1;
         if (last_byte) begin
            if (st_cur.open) begin
               recs[0] = bjs_pkg::make_rec(bjs_pkg::KIND_SEG, st, st.start, MAX_EXT[16:0]);
               n = 2'd1;
            end
            st      = '0;
            pc_next = '0;
         end
      end else begin
         if (st_cur.push_left != 6'd0) begin
            st.push_left = st_cur.push_left - 6'd1;
         end else begin
            jd = (code_byte == bjs_pkg::OPC_JUMPDEST);
            if (code_byte inside {[bjs_pkg::OPC_PUSH1:bjs_pkg::OPC_PUSH32]}) begin
               st.push_left = {1'b0, code_byte[4:0]} + 6'd1;
            end
         end
         if ((pc == '0) && !jd) begin
            st.open     = 1'b1;
            st.start    = '0;
            st.entry    = 1'b1;
            st.jump     = 1'b0;
            st.next_idx = st.next_idx + 16'd1;
            recs[n] = bjs_pkg::make_rec(bjs_pkg::KIND_MAP, st, 16'd0, 17'd0);
            n = n + 2'd1;
         end
         if (jd) begin
            // A JUMPDEST that does not follow another one closes the old segment.
            if (!st_cur.prev_jd) begin
               if (st.open) begin
                  recs[n] = bjs_pkg::make_rec(bjs_pkg::KIND_SEG, st, st.start, pc_ext[16:0]);
                  n = n + 2'd1;
               end
               st.open     = 1'b1;
               st.start    = pc_ext[15:0];
               st.entry    = (pc == '0);
               st.jump     = 1'b1;
               st.next_idx = st.next_idx + 16'd1;
            end
            recs[n] = bjs_pkg::make_rec(bjs_pkg::KIND_MAP, st, pc_ext[15:0], 17'd0);
            n = n + 2'd1;
         end
         st.prev_jd = jd;
         pc_next    = pc + PC_W'(1);
         if (last_byte) begin
            if (st.open) begin
               recs[n] = bjs_pkg::make_rec(bjs_pkg::KIND_SEG, st, st.start, pc1_ext[16:0]);
               n = n + 2'd1;
            end
            st      = '0;
            pc_next = '0;
         end
      end
      if (n != 2'd0) begin
         recs[n - 2'd1].last = 1'b1;
      end
      st_next = st;
      rec_cnt = n;
   end

endmodule

@@ sv/bytecode_jumpdest_segmenter.sv @@
// Top level of the bytecode jump-destination segmenter: state registers and a
// three-entry result queue around bjs_step. Depends on bjs_pkg and bjs_step.
//
//   channel | direction | tdata                 | tuser        | tlast
//   req     | in        | code_byte             | -            | last_byte
//   rsp     | out       | seg_index .. overflow | record_kind  | last_result
//
// A byte is analysed in the cycle it is accepted and its records are loaded into
// the result queue, so one byte per cycle is taken while each gives at most one record.
// A byte giving two or three records holds req_tready low while the queue drains.
// A stall on rsp holds the queue and, while it holds a record, the input.
// Reset is synchronous and clears the analysis state and the queue count.
module bytecode_jumpdest_segmenter #(
   parameter int unsigned MAX_CODE_BYTES = bjs_pkg::MAX_CODE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] code_byte
   input  logic                           req_tlast,   // last_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] seg_index, [31:16] start_pc, [48:32] end_pc, [49] is_entry,
   // [50] is_jumpdest, [51] code_overflow, [55:52] zero
   output logic [bjs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,   // record_kind
   output logic                           rsp_tlast    // last_result
);

   localparam int PC_W = $clog2(MAX_CODE_BYTES + 1);

   logic [PC_W-1:0]        pc_ff;
   logic [PC_W-1:0]        pc_in;
   bjs_pkg::seg_state_type state_ff;
   bjs_pkg::seg_state_type state_in;
   bjs_pkg::rec_type       step_recs [3];
   logic [1:0]             step_cnt;
   bjs_pkg::rec_type       slot_ff [3];
   bjs_pkg::rec_type       slot_in [3];
   logic [1:0]             cnt_ff;
   logic [1:0]             cnt_in;
   logic                   accept;
   logic                   pop;

   bjs_step #(
      .MAX_CODE_BYTES (MAX_CODE_BYTES),
      .PC_W           (PC_W)
   ) u_step (
      .code_byte (req_tdata),
      .last_byte (req_tlast),
      .pc        (pc_ff),
      .st_cur    (state_ff),
      .pc_next   (pc_in),
      .st_next   (state_in),
      .recs      (step_recs),
      .rec_cnt   (step_cnt)
   );

   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         // The queue is empty or empties in this cycle, so the new records replace it.
         slot_in = step_recs;
         cnt_in  = step_cnt;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         state_ff <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            pc_ff    <= pc_in;
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tuser  = slot_ff[0].kind;
   assign rsp_tlast  = slot_ff[0].last;
   assign rsp_tdata  = {4'd0, slot_ff[0].ovf, slot_ff[0].jump, slot_ff[0].entry,
                        slot_ff[0].end_pc, slot_ff[0].start_pc, slot_ff[0].idx};

endmodule

@@ sv/bjs_checker.sv @@
// Port-level checks on the segmenter's result channel, bound to the top level.
// Depends on bjs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bjs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bjs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled transaction keeps its contents until it is taken.
   `BJS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))

   // Mapping records never carry an end pc.
   `BJS_ASSERT_IMP(a_map_end_zero, rsp_tvalid && (rsp_tuser == bjs_pkg::KIND_MAP), rsp_tdata[48:32] == 17'd0)

   // A closed entry segment always starts at pc zero.
   `BJS_ASSERT_IMP(a_entry_start, rsp_tvalid && (rsp_tuser == bjs_pkg::KIND_SEG) && rsp_tdata[49], rsp_tdata[31:16] == 16'd0)

endmodule

bind bytecode_jumpdest_segmenter bjs_checker u_bjs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
